### design/hsc_pkg.sv
// Package for the structured hex mesh connectivity generator.
// Holds the transaction payload structs, block kind and register index codes,
// and sizing constants. No dependencies.
`timescale 1ns / 1ps

package hsc_pkg;

	// Largest interval count along any axis that the generator accepts.
	localparam int MAX_INTERVALS = 1024;

	// Field widths.
	localparam int KIND_W  = 3;
	localparam int IDX_W   = 10;
	localparam int CFG_W   = 11;
	localparam int NODE_W  = 31;
	localparam int COUNT_W = 4;
	localparam int CIDX_W  = 3;

	// Block kind codes; code 7 is unused and yields an invalid result.
	typedef enum logic [KIND_W-1:0] {
		KIND_HEX   = 3'd0,
		KIND_MIN_X = 3'd1,
		KIND_MAX_X = 3'd2,
		KIND_MIN_Y = 3'd3,
		KIND_MAX_Y = 3'd4,
		KIND_MIN_Z = 3'd5,
		KIND_MAX_Z = 3'd6
	} block_kind_t;

	// Configuration register indexes.
	typedef enum logic [CIDX_W-1:0] {
		CFG_NUM_X       = 3'd0,
		CFG_NUM_Y       = 3'd1,
		CFG_NUM_Z       = 3'd2,
		CFG_SLAB_START  = 3'd3,
		CFG_SLAB_LAYERS = 3'd4,
		CFG_OWNS_BOTTOM = 3'd5,
		CFG_OWNS_TOP    = 3'd6
	} cfg_reg_t;

	// Corner counts.
	localparam logic [COUNT_W-1:0] HEX_CORNERS   = 4'd8;
	localparam logic [COUNT_W-1:0] SHELL_CORNERS = 4'd4;

	// Input transaction payload.
	typedef struct packed {
		logic [KIND_W-1:0] block_kind;
		logic [IDX_W-1:0]  col;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  layer;
	} item_t;

	// Result transaction payload.
	typedef struct packed {
		logic [NODE_W-1:0]  node_a;
		logic [NODE_W-1:0]  node_b;
		logic [NODE_W-1:0]  node_c;
		logic [NODE_W-1:0]  node_d;
		logic [NODE_W-1:0]  node_e;
		logic [NODE_W-1:0]  node_f;
		logic [NODE_W-1:0]  node_g;
		logic [NODE_W-1:0]  node_h;
		logic [COUNT_W-1:0] corner_count;
		logic               valid_res;
	} result_t;

endpackage

### design/hex_shell_connectivity_gen.sv
// Top level of the structured hex mesh connectivity generator.
// Depends on hsc_pkg for payload structs, kind codes and register indexes.
//
//   Channel   Direction  Handshake                     Payload
//   item      in         item_valid / item_stall       item_t
//   result    out        result_valid / result_stall   result_t
//   cfg       in         cfg_we (write only)           cfg_index, cfg_data
//
// One transaction is accepted per cycle while item_stall is low; each result
// passes through the input register, multiply stage, and add and select stage.
// Per-stage enables let empty stages fill while the result register is stalled.
// Reset clears all stage valid bits and restores the register defaults.
// Derived geometry registers are registered from the configuration registers.
`timescale 1ns / 1ps

module hex_shell_connectivity_gen import hsc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  item_t              item,
	output logic               result_valid,
	input  logic               result_stall,
	output result_t            result,
	input  logic               cfg_we,
	input  logic [CIDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]   cfg_data
);

	// Configuration registers.
	logic [CFG_W-1:0] num_x_q;
	logic [CFG_W-1:0] num_y_q;
	logic [CFG_W-1:0] num_z_q;
	logic [IDX_W-1:0] slab_start_q;
	logic [CFG_W-1:0] slab_layers_q;
	logic             owns_bottom_q;
	logic             owns_top_q;

	// Derived geometry registers.
	logic [11:0]       rowlen_q;
	logic [12:0]       rowlen1_q;
	logic [23:0]       plane_q;
	logic [24:0]       plane1_q;
	logic [24:0]       plane_row_q;
	logic [24:0]       plane_row1_q;
	logic [23:0]       side_off_q;
	logic [NODE_W-1:0] top_off_q;

	// Pipeline registers.
	logic              v_s1, v_s2, v_s3;
	block_kind_t       kind_s1, kind_s2;
	logic [IDX_W-1:0]  col_s1, col_s2;
	logic [IDX_W-1:0]  row_s1;
	logic [IDX_W-1:0]  layer_s1;
	logic [NODE_W-1:0] lay_off_s2;
	logic [21:0]       row_off_s2;
	logic              ok_s2;
	result_t           result_s3;

	// Stage enables.
	logic en_s1, en_s2, en_s3;

	// Stage 1 logic.
	logic             col_ok, row_ok, lay_ok, cfg_bad, top_ok, ok_d;
	logic [NODE_W-1:0] lay_off_d;
	logic [21:0]       row_off_d;

	// Stage 2 logic.
	logic [NODE_W-1:0] off_sel, mid_sel, col_term, base;
	logic [NODE_W-1:0] s_0, s_1, s_r, s_r1, s_p, s_p1, s_pr, s_pr1;
	result_t           result_d;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_x_q       <= CFG_W'(1);
			num_y_q       <= CFG_W'(1);
			num_z_q       <= CFG_W'(1);
			slab_start_q  <= '0;
			slab_layers_q <= CFG_W'(1);
			owns_bottom_q <= 1'b1;
			owns_top_q    <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NUM_X:       num_x_q       <= cfg_data;
				CFG_NUM_Y:       num_y_q       <= cfg_data;
				CFG_NUM_Z:       num_z_q       <= cfg_data;
				CFG_SLAB_START:  slab_start_q  <= cfg_data[IDX_W-1:0];
				CFG_SLAB_LAYERS: slab_layers_q <= cfg_data;
				CFG_OWNS_BOTTOM: owns_bottom_q <= cfg_data[0];
				CFG_OWNS_TOP:    owns_top_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Derived geometry: row length and plane size first, then their sums and
	// the offset of the top plane in the cycle after.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rowlen_q     <= 12'd2;
			plane_q      <= 24'd4;
			rowlen1_q    <= 13'd3;
			plane1_q     <= 25'd5;
			plane_row_q  <= 25'd6;
			plane_row1_q <= 25'd7;
			side_off_q   <= 24'd2;
			top_off_q    <= NODE_W'(4);
		end else begin
			rowlen_q     <= 12'(num_x_q) + 12'd1;
			plane_q      <= (12'(num_x_q) + 12'd1) * (12'(num_y_q) + 12'd1);
			rowlen1_q    <= 13'(rowlen_q) + 13'd1;
			plane1_q     <= 25'(plane_q) + 25'd1;
			plane_row_q  <= 25'(plane_q) + 25'(rowlen_q);
			plane_row1_q <= 25'(plane_q) + 25'(rowlen_q) + 25'd1;
			side_off_q   <= plane_q - 24'(rowlen_q);
			top_off_q    <= NODE_W'(35'(plane_q) * 35'(num_z_q - CFG_W'(slab_start_q)));
		end
	end

	// Handshake: a stage loads when it is empty or its successor loads.
	assign en_s3      = !v_s3 || !result_stall;
	assign en_s2      = !v_s2 || en_s3;
	assign en_s1      = !v_s1 || en_s2;
	assign item_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= item_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	// Stage 1: input register.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			kind_s1  <= block_kind_t'(item.block_kind);
			col_s1   <= item.col;
			row_s1   <= item.row;
			layer_s1 <= item.layer;
		end
	end

	// Range and ownership checks for the indices each kind uses.
	assign col_ok  = CFG_W'(col_s1) < num_x_q;
	assign row_ok  = CFG_W'(row_s1) < num_y_q;
	assign lay_ok  = CFG_W'(layer_s1) < slab_layers_q;
	assign top_ok  = owns_top_q && (CFG_W'(slab_start_q) <= num_z_q);
	assign cfg_bad = (num_x_q > CFG_W'(MAX_INTERVALS)) || (num_y_q > CFG_W'(MAX_INTERVALS)) ||
		(num_z_q > CFG_W'(MAX_INTERVALS)) || (slab_layers_q > CFG_W'(MAX_INTERVALS));

	always_comb begin
		case (kind_s1)
			KIND_HEX:   ok_d = col_ok && row_ok && lay_ok;
			KIND_MIN_X,
			KIND_MAX_X: ok_d = row_ok && lay_ok;
			KIND_MIN_Y,
			KIND_MAX_Y: ok_d = col_ok && lay_ok;
			KIND_MIN_Z: ok_d = col_ok && row_ok && owns_bottom_q;
			KIND_MAX_Z: ok_d = col_ok && row_ok && top_ok;
			default:    ok_d = 1'b0;
		endcase
		ok_d = ok_d && !cfg_bad;
	end

	// Layer and row offsets; ids wrap modulo 2^31.
	assign lay_off_d = NODE_W'(34'(layer_s1) * 34'(plane_q));
	assign row_off_d = 22'(row_s1) * 22'(rowlen_q);

	// Stage 2: product register.
	always_ff @(posedge clk) begin
		if (en_s2) begin
			kind_s2    <= kind_s1;
			col_s2     <= col_s1;
			lay_off_s2 <= lay_off_d;
			row_off_s2 <= row_off_d;
			ok_s2      <= ok_d;
		end
	end

	// Base node of the element: plane offset, row offset and column term.
	always_comb begin
		case (kind_s2)
			KIND_MIN_Z: off_sel = '0;
			KIND_MAX_Z: off_sel = top_off_q;
			default:    off_sel = lay_off_s2;
		endcase
		case (kind_s2)
			KIND_MIN_Y: mid_sel = '0;
			KIND_MAX_Y: mid_sel = NODE_W'(side_off_q);
			default:    mid_sel = NODE_W'(row_off_s2);
		endcase
		case (kind_s2)
			KIND_MIN_X: col_term = NODE_W'(1);
			KIND_MAX_X: col_term = NODE_W'(rowlen_q);
			default:    col_term = NODE_W'(col_s2) + NODE_W'(1);
		endcase
	end

	assign base = off_sel + mid_sel + col_term;

	// The eight candidate corners around the base node.
	assign s_0   = base;
	assign s_1   = base + NODE_W'(1);
	assign s_r   = base + NODE_W'(rowlen_q);
	assign s_r1  = base + NODE_W'(rowlen1_q);
	assign s_p   = base + NODE_W'(plane_q);
	assign s_p1  = base + NODE_W'(plane1_q);
	assign s_pr  = base + NODE_W'(plane_row_q);
	assign s_pr1 = base + NODE_W'(plane_row1_q);

	// Corner order per face; an invalid result is all zero.
	always_comb begin
		result_d = '0;
		if (ok_s2) begin
			result_d.valid_res    = 1'b1;
			result_d.corner_count = SHELL_CORNERS;
			result_d.node_a       = s_0;
			case (kind_s2)
				KIND_HEX: begin
					result_d.corner_count = HEX_CORNERS;
					result_d.node_b = s_1;
					result_d.node_c = s_r1;
					result_d.node_d = s_r;
					result_d.node_e = s_p;
					result_d.node_f = s_p1;
					result_d.node_g = s_pr1;
					result_d.node_h = s_pr;
				end
				KIND_MIN_X: begin
					result_d.node_b = s_p;
					result_d.node_c = s_pr;
					result_d.node_d = s_r;
				end
				KIND_MAX_X: begin
					result_d.node_b = s_r;
					result_d.node_c = s_pr;
					result_d.node_d = s_p;
				end
				KIND_MIN_Y: begin
					result_d.node_b = s_1;
					result_d.node_c = s_p1;
					result_d.node_d = s_p;
				end
				KIND_MAX_Y: begin
					result_d.node_b = s_p;
					result_d.node_c = s_p1;
					result_d.node_d = s_1;
				end
				KIND_MIN_Z: begin
					result_d.node_b = s_r;
					result_d.node_c = s_r1;
					result_d.node_d = s_1;
				end
				default: begin
					result_d.node_b = s_1;
					result_d.node_c = s_r1;
					result_d.node_d = s_r;
				end
			endcase
		end
	end

	// Stage 3: result register.
	always_ff @(posedge clk) begin
		if (en_s3) begin
			result_s3 <= result_d;
		end
	end

	assign result_valid = v_s3;
	assign result       = result_s3;

endmodule
